// ===== rtl/searchable_lifo_stack_core_defines.svh =====
// ---------------------------------------------------------------------------
// searchable_lifo_stack_core_defines.svh
// Assertion macros for the searchable LIFO stack core.
// ---------------------------------------------------------------------------
`ifndef SEARCHABLE_LIFO_STACK_CORE_DEFINES_SVH
`define SEARCHABLE_LIFO_STACK_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define SLSK_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that a condition implies another one in the next cycle.
`define SLSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLSK_ASSERT(label, expr, msg)
`define SLSK_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/slsk_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slsk_pkg
// Types and constants shared by the searchable LIFO stack core.
// ---------------------------------------------------------------------------
package slsk_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int DEPTH_W     = $clog2(MAX_ENTRIES + 1);
    localparam int DATA_W      = 32;
    localparam int COUNT_W     = 7;

    localparam logic signed [DATA_W-1:0] EMPTY_TOP = 32'sd9999;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_empty;
        logic                     is_member;
        logic [COUNT_W-1:0]       less_count;
        logic                     push_dropped;
    } res_t;

endpackage

// ===== rtl/slsk_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slsk_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module slsk_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/slsk_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slsk_ctrl
// Stack sequencer: applies push or pop, then scans held entries one a cycle.
// ---------------------------------------------------------------------------
module slsk_ctrl
    import slsk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              done_valid,
    input  logic              done_ready,
    output res_t              done,
    output logic              ram_wr_en,
    output logic [ADDR_W-1:0] ram_wr_addr,
    output logic [DATA_W-1:0] ram_wr_data,
    output logic              ram_rd_en,
    output logic [ADDR_W-1:0] ram_rd_addr,
    input  logic [DATA_W-1:0] ram_rd_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [DEPTH_W-1:0]       depth_reg, depth_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic                     issue_reg, issue_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic                     rd_last_reg, rd_last_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic [DEPTH_W-1:0]       less_reg, less_next;
    logic                     member_reg, member_next;
    logic                     dropped_reg, dropped_next;

    logic [DEPTH_W-1:0]       new_depth;
    logic                     scan_last;
    logic signed [DATA_W-1:0] entry;

    assign entry     = $signed(ram_rd_data);
    assign scan_last = (DEPTH_W'(idx_reg) + DEPTH_W'(1)) == depth_reg;

    always_comb
    begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        idx_next      = idx_reg;
        issue_next    = issue_reg;
        key_next      = key_reg;
        top_next      = top_reg;
        less_next     = less_reg;
        member_next   = member_reg;
        dropped_next  = dropped_reg;
        new_depth     = depth_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = depth_reg[ADDR_W-1:0];
        ram_wr_data   = cmd.value;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    key_next     = cmd.value;
                    dropped_next = 1'b0;
                    member_next  = 1'b0;
                    less_next    = '0;
                    idx_next     = '0;
                    case (cmd.op)
                        OP_PUSH:
                        begin
                            if (depth_reg == DEPTH_W'(MAX_ENTRIES))
                            begin
                                dropped_next = 1'b1;
                            end
                            else
                            begin
                                ram_wr_en = 1'b1;
                                new_depth = depth_reg + DEPTH_W'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (depth_reg != '0)
                            begin
                                new_depth = depth_reg - DEPTH_W'(1);
                            end
                        end
                        default:
                        begin
                            new_depth = depth_reg;
                        end
                    endcase
                    depth_next = new_depth;
                    if (new_depth == '0)
                    begin
                        top_next   = EMPTY_TOP;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        issue_next = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue reads bottom to top; compare the data in the cycle after each read.
                if (issue_reg)
                begin
                    ram_rd_en = 1'b1;
                    idx_next  = idx_reg + ADDR_W'(1);
                    if (scan_last)
                    begin
                        issue_next = 1'b0;
                    end
                end
                if (rd_valid_reg)
                begin
                    if (entry == key_reg)
                    begin
                        member_next = 1'b1;
                    end
                    if (entry < key_reg)
                    begin
                        less_next = less_reg + DEPTH_W'(1);
                    end
                    if (rd_last_reg)
                    begin
                        top_next   = entry;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (done_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_valid_next = ram_rd_en;
    assign rd_last_next  = ram_rd_en && scan_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            depth_reg    <= '0;
            idx_reg      <= '0;
            issue_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            key_reg      <= '0;
            top_reg      <= '0;
            less_reg     <= '0;
            member_reg   <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            idx_reg      <= idx_next;
            issue_reg    <= issue_next;
            rd_valid_reg <= rd_valid_next;
            rd_last_reg  <= rd_last_next;
            key_reg      <= key_next;
            top_reg      <= top_next;
            less_reg     <= less_next;
            member_reg   <= member_next;
            dropped_reg  <= dropped_next;
        end
    end

    assign cmd_ready  = (state_reg == ST_IDLE);
    assign done_valid = (state_reg == ST_DONE);

    always_comb
    begin
        done.top_value    = top_reg;
        done.entry_count  = COUNT_W'(depth_reg);
        done.is_empty     = (depth_reg == '0);
        done.is_member    = member_reg;
        done.less_count   = COUNT_W'(less_reg);
        done.push_dropped = dropped_reg;
    end

endmodule

// ===== rtl/searchable_lifo_stack_core.sv =====
`timescale 1ns / 1ps
// Flow: one item at a time; the sequencer takes a new command only once it has
//          handed its result to the output register. An empty stack skips the scan,
//          otherwise the scan reads every held entry through the RAM read port.
// Reset: rst_n clears the depth, the sequencer and the output register; the
//          entry RAM is not cleared, and no clearing pass runs.
// ---------------------------------------------------------------------------
// searchable_lifo_stack_core
// Bounded LIFO of signed 32-bit values with membership and less-than search.
// ---------------------------------------------------------------------------
`include "searchable_lifo_stack_core_defines.svh"

module searchable_lifo_stack_core
    import slsk_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    // Sequencer to output register handshake.
    logic done_valid;
    logic done_ready;
    res_t done;

    // RAM ports.
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    // Output register: holds a finished item so the sequencer can take the
    // next command while the consumer stalls.
    logic res_valid_reg, res_valid_next;
    res_t res_reg, res_next;

    // The entry store. Entry 0 is the bottom of the stack; the top lives at
    // depth - 1. Entries above the depth are never read.
    slsk_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The sequencer applies push or pop at accept (the write lands before
    // the first scan read, so a pushed value is seen by its own query), then
    // streams every held entry through one comparator. The last read is the
    // top entry.
    slsk_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .done_valid  (done_valid),
        .done_ready  (done_ready),
        .done        (done),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // Load a new item when the register is empty or being drained.
    assign done_ready = !res_valid_reg || res_ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (done_ready)
        begin
            res_valid_next = done_valid;
            if (done_valid)
            begin
                res_next = done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // An empty stack reports the sentinel and no matches.
    `SLSK_ASSERT(a_empty_result, !(res_valid && res.is_empty) || (res.top_value == EMPTY_TOP && res.entry_count == '0 && !res.is_member && res.less_count == '0), "empty stack result is inconsistent")
    // A dropped push only happens on a full stack.
    `SLSK_ASSERT(a_drop_full, !(res_valid && res.push_dropped) || res.entry_count == COUNT_W'(MAX_ENTRIES), "push dropped while stack not full")
    // One item at a time: no accept in the cycle after an accept.
    `SLSK_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "command taken while busy")

endmodule

// ===== sim/tb_searchable_lifo_stack_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_searchable_lifo_stack_core
// Self-checking bench for the searchable LIFO stack core. A queued driver
// offers push, pop and query items with random gaps. A shadow stack works out
// the status item that each accepted item must produce. A monitor with random
// back-pressure, and one long hold-off, compares every status item field by
// field.
// ---------------------------------------------------------------------------
module tb_searchable_lifo_stack_core;
    import slsk_pkg::*;

    // Spare operation code: the core treats it as a plain query.
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    localparam int unsigned ITEM_TARGET  = 1050;
    // Start the long receiver hold-off once this many status items are in.
    localparam int unsigned HOLD_AFTER   = 400;
    localparam int unsigned HOLD_CYCLES  = 600;
    // A full stack scans 64 entries, plus the sequencer overhead.
    localparam int unsigned DRAIN_CYCLES = MAX_ENTRIES + 16;
    // Slowest legal item: the longest sender gap, a full-stack scan in the core
    // and the longest receiver stall. The limit allows several times the run
    // of about 1100 items at that pace.
    localparam int unsigned CYCLE_LIMIT  = 600_000;

    typedef struct packed {
        cmd_t       cmd;
        logic [4:0] gap;
    } cmd_slot_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd       = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    // Stimulus backlog and the status items still owed by the core.
    cmd_slot_t         cmd_backlog[$];
    res_t              status_due[$];
    logic [DATA_W-1:0] recent_keys[$];
    int unsigned       items_queued    = 0;
    logic              sender_calm     = 1'b0;

    // Shadow copy of the stack contents.
    logic signed [DATA_W-1:0] shadow_entries [MAX_ENTRIES];
    int unsigned              shadow_depth = 0;

    int unsigned failures        = 0;
    int unsigned results_checked = 0;
    int unsigned cycle_count     = 0;
    int unsigned hold_left       = 0;
    logic        hold_spent      = 1'b0;
    logic        hold_on;

    // Driver-private bookkeeping.
    cmd_slot_t   next_slot;
    logic        gap_armed = 1'b0;
    int unsigned gap_left  = 0;

    // Monitor-private stall counter.
    int unsigned stall_left = 0;

    searchable_lifo_stack_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one accepted item to the shadow stack and queue the status item
    // that the core owes for it.
    function automatic void stack_apply(input cmd_t item);
        res_t                     status;
        logic signed [DATA_W-1:0] key;
        int unsigned              below;
        status = '0;
        key    = item.value;
        below  = 0;
        if (item.op == OP_PUSH)
        begin
            // Drop the push and flag it when the stack is already full.
            if (shadow_depth >= MAX_ENTRIES)
                status.push_dropped = 1'b1;
            else
            begin
                shadow_entries[shadow_depth] = key;
                shadow_depth++;
            end
        end
        else if (item.op == OP_POP)
        begin
            // A pop on an empty stack leaves everything alone.
            if (shadow_depth != 0)
                shadow_depth--;
        end
        // Search the entries held after the operation, signed compare.
        for (int i = 0; i < shadow_depth; i++)
        begin
            if (shadow_entries[i] == key)
                status.is_member = 1'b1;
            if (shadow_entries[i] < key)
                below++;
        end
        status.top_value   = (shadow_depth != 0) ? shadow_entries[shadow_depth - 1]
                                                 : EMPTY_TOP;
        status.entry_count = COUNT_W'(shadow_depth);
        status.is_empty    = (shadow_depth == 0);
        status.less_count  = COUNT_W'(below);
        status_due.push_back(status);
    endfunction

    function automatic void check_field(input string name,
                                        input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    function automatic void check_status(input res_t got);
        res_t want;
        if (status_due.size() == 0)
        begin
            $error("status item with none outstanding: top_value 0x%0h",
                   got.top_value);
            failures++;
            return;
        end
        want = status_due.pop_front();
        check_field("top_value",    want.top_value,    got.top_value);
        check_field("entry_count",  want.entry_count,  got.entry_count);
        check_field("is_empty",     want.is_empty,     got.is_empty);
        check_field("is_member",    want.is_member,    got.is_member);
        check_field("less_count",   want.less_count,   got.less_count);
        check_field("push_dropped", want.push_dropped, got.push_dropped);
    endfunction

    // Draw a value: mostly small numbers and recently pushed keys so that
    // membership hits and ties happen often, plus extremes and raw noise.
    function automatic logic [DATA_W-1:0] pick_value();
        int unsigned       kind;
        int                near_zero;
        logic [DATA_W-1:0] base;
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            near_zero = int'($urandom_range(0, 16)) - 8;
            return near_zero;
        end
        if (kind == 4)
        begin
            case ($urandom_range(0, 6))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return VAL_MIN + 1;
                3:       return VAL_MAX - 1;
                4:       return EMPTY_TOP;
                5:       return '1;
                default: return '0;
            endcase
        end
        if (kind < 7 && recent_keys.size() != 0)
        begin
            base = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            return base + DATA_W'($urandom_range(0, 2)) - 1'b1;
        end
        return $urandom();
    endfunction

    function automatic void queue_cmd(input logic [1:0] op, input logic [DATA_W-1:0] value);
        cmd_slot_t slot;
        slot.cmd.op    = op;
        slot.cmd.value = value;
        slot.gap       = sender_calm ? 5'd0 : 5'($urandom_range(0, 16));
        cmd_backlog.push_back(slot);
        items_queued++;
        if (op == OP_PUSH)
        begin
            recent_keys.push_back(value);
            if (recent_keys.size() > 32)
                recent_keys.delete(0);
        end
    endfunction

    // Driver: hold each item until accepted, predict it on the accepting
    // edge, then idle for the next item's gap before offering it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
            gap_armed = 1'b0;
            gap_left  = 0;
        end
        else
        begin
            if (cmd_valid && cmd_ready)
                stack_apply(cmd);
            // The slot is free when nothing is offered or the offer just went.
            if (!cmd_valid || cmd_ready)
            begin
                if (!gap_armed && cmd_backlog.size() != 0)
                begin
                    gap_left  = cmd_backlog[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_armed && gap_left == 0)
                begin
                    next_slot = cmd_backlog.pop_front();
                    cmd_valid <= 1'b1;
                    cmd       <= next_slot.cmd;
                    gap_armed = 1'b0;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left = gap_left - 1;
                end
            end
        end
    end

    // Monitor: check each accepted status item, then stall for a random
    // number of cycles. Every third stretch of 128 items runs without stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                check_status(res);
                results_checked <= results_checked + 1;
                if (((results_checked / 128) % 3) == 1)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 16);
            end
            else if (stall_left != 0)
                stall_left = stall_left - 1;
            res_ready <= (stall_left == 0) && !hold_on;
        end
    end

    // Long hold-off: block the result side once, well into the run, while
    // the driver keeps offering, so the core backs up and drops cmd_ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_spent <= 1'b0;
        end
        else if (!hold_spent && results_checked >= HOLD_AFTER)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_spent <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    assign hold_on = (hold_left != 0);

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned seg_len;
        int unsigned push_pct;
        int unsigned draw;
        logic [1:0]  op;

        // Directed opening: empty-stack corners, the spare code, extreme keys,
        // a value equal to the empty marker, a duplicate, and a drain that
        // ends with a pop on an empty stack.
        queue_cmd(OP_QUERY, '0);
        queue_cmd(OP_POP, 32'd7);
        queue_cmd(OP_SPARE, 32'd5);
        queue_cmd(OP_PUSH, VAL_MIN);
        queue_cmd(OP_PUSH, VAL_MAX);
        queue_cmd(OP_PUSH, '0);
        queue_cmd(OP_PUSH, '1);
        queue_cmd(OP_PUSH, EMPTY_TOP);
        queue_cmd(OP_PUSH, '1);
        queue_cmd(OP_QUERY, VAL_MIN);
        queue_cmd(OP_QUERY, VAL_MAX);
        queue_cmd(OP_QUERY, '0);
        queue_cmd(OP_QUERY, '1);
        queue_cmd(OP_QUERY, 32'd1);
        queue_cmd(OP_QUERY, EMPTY_TOP);
        queue_cmd(OP_SPARE, VAL_MAX);
        repeat (7)
            queue_cmd(OP_POP, pick_value());
        queue_cmd(OP_QUERY, VAL_MIN);

        // Fill to the brim and push past it, search the full stack, then
        // drain past empty.
        for (int i = 0; i < MAX_ENTRIES + 3; i++)
            queue_cmd(OP_PUSH, pick_value());
        queue_cmd(OP_QUERY, pick_value());
        queue_cmd(OP_SPARE, pick_value());
        queue_cmd(OP_QUERY, VAL_MAX);
        for (int i = 0; i < MAX_ENTRIES + 2; i++)
            queue_cmd(OP_POP, pick_value());

        // Random segments, each biased toward growing, holding or shrinking
        // the stack so that both full and empty are visited again and again.
        while (items_queued < ITEM_TARGET)
        begin
            seg_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 50;
                default: push_pct = 15;
            endcase
            sender_calm = ($urandom_range(0, 3) == 0);
            repeat (seg_len)
            begin
                if ($urandom_range(0, 99) < push_pct)
                    op = OP_PUSH;
                else
                begin
                    draw = $urandom_range(0, 9);
                    if (draw < 6)
                        op = OP_POP;
                    else if (draw < 9)
                        op = OP_QUERY;
                    else
                        op = OP_SPARE;
                end
                queue_cmd(op, pick_value());
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to go in and every status item to come back.
        while (cmd_backlog.size() != 0 || cmd_valid || status_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (status_due.size() != 0)
        begin
            $error("%0d status items never arrived", status_due.size());
            failures++;
        end
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
